// File: sv/ins_sort_pkg.sv
// Shared types and constants for the insertion sorter.
package ins_sort_pkg;

   localparam int WORD_W = 32;

   // One-hot controller states.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

// File: sv/ins_sort_cell.sv
// One cell of the sorting chain: holds one stored value.
module ins_sort_cell
   import ins_sort_pkg::*;
(
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic                     occupied,
   input  logic signed [WORD_W-1:0] new_value,
   input  logic                     ge_left,
   input  logic signed [WORD_W-1:0] left_value,
   input  logic signed [WORD_W-1:0] right_value,
   output logic                     ge_self,
   output logic signed [WORD_W-1:0] value
);

   logic signed [WORD_W-1:0] value_ff;
   logic signed [WORD_W-1:0] value_in;

   // An empty cell, or one whose value is not below the new one, must move.
   assign ge_self = !occupied || (value_ff >= new_value);

   // Keep, take the left neighbor's value, take the new value, or shift left.
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && ge_self) begin
         if (ge_left) begin
            value_in = left_value;
         end else begin
            value_in = new_value;
         end
      end else if (ctrl.shift) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: sv/insertion_sorter.sv
// Top level of the insertion sorter: controller and the chain of cells.
//
// The sorter keeps up to DEPTH signed values in a chain of cells, in
// ascending order. An item is inserted as it arrives: every cell compares the
// arriving value with its own at once and either keeps its value, takes its
// left neighbor's, or takes the new value. Values beyond DEPTH are dropped
// and the overflow flag is set. On an item marked last, the value is inserted
// (or dropped if the chain is full) and then the whole list is emitted one
// item per cycle while rsp_ready is high, in ascending order, by shifting
// the chain toward cell 0; no item is accepted until the list is emitted.
// The final result carries rsp_last_result, and every result carries the
// overflow flag of its list. Count and flag are cleared after the final item.
module insertion_sorter
   import ins_sort_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     req_last_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_sorted_value,
   output logic                     rsp_last_result,
   output logic                     rsp_overflowed
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            flag_ff, flag_in;
   cell_ctrl_type   ctrl;
   logic            req_take;
   logic            rsp_take;
   logic            full;

   logic                     ge   [DEPTH];
   logic signed [WORD_W-1:0] cval [DEPTH];
   logic                     occ  [DEPTH];

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));

   assign ctrl.insert = req_take && !full;
   assign ctrl.shift  = rsp_take;

   // Results come straight from the head cell.
   assign rsp_sorted_value = cval[0];
   assign rsp_last_result  = (count_ff == CNT_W'(1));
   assign rsp_overflowed   = flag_ff;

   // Controller: insert in idle, drain after a last item.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      flag_in  = flag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (full) begin
                  flag_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_take) begin
               count_in = count_ff - CNT_W'(1);
               if (rsp_last_result) begin
                  flag_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

   // The chain of cells, cell 0 holding the smallest value.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     ge_l;
      logic signed [WORD_W-1:0] left_v;
      logic signed [WORD_W-1:0] right_v;

      assign occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign ge_l   = 1'b0;
         assign left_v = req_value;
      end else begin : g_body
         assign ge_l   = ge[i-1];
         assign left_v = cval[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_v = '0;
      end else begin : g_inner
         assign right_v = cval[i+1];
      end

      ins_sort_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ[i]),
         .new_value   (req_value),
         .ge_left     (ge_l),
         .left_value  (left_v),
         .right_value (right_v),
         .ge_self     (ge[i]),
         .value       (cval[i])
      );
   end

endmodule
